@@ rtl/keyed_byte_stream_obfuscator_macros.svh @@
// Assertion helpers for the obfuscator RTL.
`ifndef KEYED_BYTE_STREAM_OBFUSCATOR_MACROS_SVH
`define KEYED_BYTE_STREAM_OBFUSCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is applied
`define KBSO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kbso assertion failed");

// Next-cycle implication, masked while reset is applied
`define KBSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kbso assertion failed");

`endif

@@ rtl/kbso_pkg.sv @@
`default_nettype none
package kbso_pkg;

    localparam int unsigned KEY_W     = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDX_W     = 12;
    localparam int unsigned CNT_W     = 12;

    // Mixing constants of the keystream
    localparam logic [KEY_W-1:0] SEED_MIX = 64'hafcb_8f2f_f4ff_f33f;
    localparam logic [KEY_W-1:0] STEP_MIX = 64'hfcbf_aff8_f2f4_f3f0;

    // One remainder bit per cycle
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(KEY_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_EMIT,
        ST_MUL,
        ST_DIV
    } t_kbso_fsm;

    // One reseed step: XOR with the mix constant, rotate left by one
    function automatic logic [KEY_W-1:0] seed_step(input logic [KEY_W-1:0] s);
        logic [KEY_W-1:0] x;
        x = s ^ SEED_MIX;
        return {x[KEY_W-2:0], x[KEY_W-1]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/kbso_in_if.sv @@
`default_nettype none
interface kbso_in_if;
    logic                          valid;
    logic                          ready;
    logic [kbso_pkg::BYTE_W-1:0]   data_byte;
    logic [kbso_pkg::IDX_W-1:0]    entry_index;
    logic                          restart;

    modport source (output valid, output data_byte, output entry_index, output restart,
                    input ready);
    modport sink   (input valid, input data_byte, input entry_index, input restart,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/kbso_out_if.sv @@
`default_nettype none
interface kbso_out_if;
    logic                          valid;
    logic                          ready;
    logic [kbso_pkg::BYTE_W-1:0]   out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/keyed_byte_stream_obfuscator.sv @@
// Keyed byte stream obfuscator.
// i_in (valid/ready) carries one byte item with entry_index and restart; o_out
// (valid/ready) returns the obfuscated byte, one result item per input item.
// The key is written through i_cfg_we / i_cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Each item runs in sequence: accept, reseed when restart is set (one rotate
// step per entry_index), emit the byte, one 8x64 multiply-add, then a
// restoring remainder unit producing one bit per cycle.
// The emit step follows acceptance, or the seed steps when restart is set;
// in it the byte is written to the output register.
// The result is held in an output register, so the next item starts as soon
// as the state update finishes even if the receiver has not taken the byte.
// If the receiver stalls, the block waits in the emit step until the output
// register frees up. Entry indexes beyond the last entry cannot occur at 12 bits.
// Reset (synchronous, active low) sets the key to 1, the keystream to zero
// and empties the output register.
`default_nettype none
module keyed_byte_stream_obfuscator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [kbso_pkg::KEY_W-1:0]  i_cfg_wdata,
    kbso_in_if.sink                          i_in,
    kbso_out_if.source                       o_out
);
    import kbso_pkg::*;

    `include "keyed_byte_stream_obfuscator_macros.svh"

    t_kbso_fsm          r_fsm, n_fsm;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_state, n_state;
    logic [KEY_W-1:0]   r_rem, n_rem;
    logic [KEY_W-1:0]   r_dvd, n_dvd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  r_data;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;

    logic               in_fire;
    logic               emit_fire;
    logic               slot_free;
    logic [KEY_W:0]     div_trial;
    logic [KEY_W:0]     div_diff;
    logic [KEY_W-1:0]   div_rem;
    logic [KEY_W-1:0]   mul_prod;
    logic [KEY_W-1:0]   mul_sum;

    // Handshake and step strobes
    always_comb begin
        slot_free  = !r_out_valid || o_out.ready;
        i_in.ready = (r_fsm == ST_IDLE);
        in_fire    = i_in.valid && (r_fsm == ST_IDLE);
        emit_fire  = (r_fsm == ST_EMIT) && slot_free;
    end

    // Shared datapath: multiply-add and one restoring remainder step
    always_comb begin
        mul_prod  = r_key[15:8] * r_state;
        mul_sum   = {mul_prod[KEY_W-BYTE_W-1:0], {BYTE_W{1'b0}}}
                    + {{(KEY_W-BYTE_W){1'b0}}, r_key[7:0]};
        div_trial = {r_rem, r_dvd[KEY_W-1]};
        div_diff  = div_trial - {1'b0, r_key};
        div_rem   = div_diff[KEY_W] ? div_trial[KEY_W-1:0] : div_diff[KEY_W-1:0];
    end

    // Next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.restart && (i_in.entry_index != '0)) begin
                        n_fsm = ST_SEED;
                    end else begin
                        n_fsm = ST_EMIT;
                    end
                end
            end
            ST_SEED: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_fsm = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    n_fsm = ST_MUL;
                end
            end
            ST_MUL: begin
                n_fsm = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    // Datapath register updates per state
    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        unique case (r_fsm)
            ST_IDLE: begin
                if (in_fire && i_in.restart) begin
                    n_state = r_key;
                    n_cnt   = CNT_W'(i_in.entry_index);
                end
            end
            ST_SEED: begin
                n_state = seed_step(r_state);
                n_cnt   = r_cnt - CNT_W'(1);
            end
            ST_EMIT: begin
            end
            ST_MUL: begin
                n_dvd = mul_sum;
                n_rem = '0;
                n_cnt = DIV_STEPS;
            end
            ST_DIV: begin
                n_rem = div_rem;
                n_dvd = {r_dvd[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = div_rem ^ STEP_MIX;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_key       <= KEY_W'(1);
            r_state     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_fsm   <= n_fsm;
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        if (in_fire) begin
            r_data <= i_in.data_byte;
        end
        if (emit_fire) begin
            r_out_byte <= r_data ^ r_state[BYTE_W-1:0];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    // Checks
    `KBSO_ASSERT_NOW(a_cnt_live, i_clk, i_rst_n, (r_fsm == ST_SEED || r_fsm == ST_DIV), (r_cnt != '0))
    `KBSO_ASSERT_NOW(a_rem_below_key, i_clk, i_rst_n, (r_fsm == ST_DIV && r_key != '0), (r_rem < r_key))
    `KBSO_ASSERT_NEXT(a_plain_to_emit, i_clk, i_rst_n, (in_fire && !i_in.restart), (r_fsm == ST_EMIT))
    `KBSO_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, emit_fire, (r_out_valid && r_fsm == ST_MUL))

endmodule
`default_nettype wire
